[rtl/core/fekset_pkg.sv]
// Package: shared constants and types of the FIFO-evicting key set.
package fekset_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_W       = 64;
    localparam int CAP_W       = 5;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

    // Probe presented to the key store by the input stage
    typedef struct packed
    {
        logic    commit;
        opcode_t opcode;
    } probe_t;

    // Outcome of a probe
    typedef struct packed
    {
        logic evicted;
        logic hit;
    } outcome_t;

endpackage

[rtl/core/fekset_store.sv]
// Key store: ring of key slots with valid bits, parallel match and FIFO eviction.
module fekset_store
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [fekset_pkg::CAP_W-1:0] capacity,
    input  fekset_pkg::probe_t         probe,
    input  logic [fekset_pkg::KEY_W-1:0] probe_key,
    output fekset_pkg::outcome_t       outcome
);
    import fekset_pkg::*;

    logic [KEY_W-1:0]       key_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;
    logic [IDX_W-1:0]       write_slot_reg;
    logic [IDX_W-1:0]       write_slot_next;
    logic [CNT_W-1:0]       held_count_reg;
    logic [CNT_W-1:0]       held_count_next;

    logic [MAX_ENTRIES-1:0] match;
    logic [CNT_W-1:0]       eff_cap;
    logic [IDX_W-1:0]       held_low;
    logic [IDX_W-1:0]       oldest;
    logic                   do_write;
    logic                   do_evict;

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_match
            assign match[g] = valid_reg[g] && (key_mem[g] == probe_key);
        end
    endgenerate

    always_comb
    begin
        if (capacity == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (32'(capacity) > MAX_ENTRIES)
        begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = CNT_W'(capacity);
        end
    end

    always_comb
    begin
        held_low = (held_count_reg == CNT_W'(MAX_ENTRIES)) ? '0 : IDX_W'(held_count_reg);
        if (write_slot_reg >= held_low)
        begin
            oldest = write_slot_reg - held_low;
        end
        else
        begin
            oldest = IDX_W'(32'(write_slot_reg) + MAX_ENTRIES - 32'(held_low));
        end
    end

    assign outcome.hit     = |match;
    assign do_write        = (probe.opcode == OP_INSERT) && !outcome.hit;
    assign outcome.evicted = do_write && (held_count_reg >= eff_cap)
                             && (held_count_reg != '0);
    assign do_evict        = probe.commit && outcome.evicted;

    always_comb
    begin
        valid_next      = valid_reg;
        write_slot_next = write_slot_reg;
        held_count_next = held_count_reg;
        if (probe.commit && do_write)
        begin
            if (do_evict)
            begin
                valid_next[oldest] = 1'b0;
            end
            else
            begin
                held_count_next = held_count_reg + CNT_W'(1);
            end
            valid_next[write_slot_reg] = 1'b1;
            if (32'(write_slot_reg) == MAX_ENTRIES - 1)
            begin
                write_slot_next = '0;
            end
            else
            begin
                write_slot_next = write_slot_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            write_slot_reg <= '0;
            held_count_reg <= '0;
        end
        else
        begin
            valid_reg      <= valid_next;
            write_slot_reg <= write_slot_next;
            held_count_reg <= held_count_next;
        end
    end

    // Key slots carry no reset: a slot is only compared once its valid bit is set
    always_ff @(posedge clk)
    begin
        if (probe.commit && do_write)
        begin
            key_mem[write_slot_reg] <= probe_key;
        end
    end

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(held_count_reg))
        else $error("held count differs from number of valid slots");

    a_evict_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_evict |=> $stable(held_count_reg))
        else $error("eviction changed the held count");

    a_lookup_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (probe.commit && probe.opcode == OP_LOOKUP) |=>
            ($stable(valid_reg) && $stable(write_slot_reg)))
        else $error("lookup altered the set");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(held_count_reg) <= MAX_ENTRIES)
        else $error("held count above slot count");
`endif

endmodule

[rtl/core/fifo_evicting_key_set.sv]
// Top level: FIFO-evicting 64-bit key set with stream input and result channels.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  s_*     | in        | s_tvalid / s_tready   | s_tdata = key, s_tuser = opcode
//  m_*     | out       | m_tvalid / m_tready   | m_tdata = {6'b0, evicted, hit}
//  cfg_*   | in        | cfg_we (no wait)      | cfg_wdata = capacity
//
//  One item per cycle sustained while m_tready is high; each item passes the input
//  register, then the result register. The rate is set by the combinational
//  parallel compare against all key slots and the ring write pointer update.
//  Reset empties the set, zeroes the ring pointer and sets capacity to 16.
//  While m_tready is low the result holds; the input register still takes one item,
//  then s_tready drops until the result is taken.
module fifo_evicting_key_set
(
    input  logic                           clk,
    input  logic                           rst_n,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [63:0]                    s_tdata,   // [63:0] key
    input  logic                           s_tuser,   // [0] opcode
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [0] hit, [1] evicted, [7:2] zero
    // configuration
    input  logic                           cfg_we,
    input  logic [fekset_pkg::CAP_W-1:0]   cfg_wdata
);
    import fekset_pkg::*;

    logic [CAP_W-1:0] capacity_reg;

    logic             in_valid_reg;
    opcode_t          in_op_reg;
    logic [KEY_W-1:0] in_key_reg;

    logic             out_valid_reg;
    outcome_t         out_res_reg;

    logic             out_advance;
    logic             commit;
    probe_t           probe;
    outcome_t         outcome;

    // Result register frees up when empty or when its transfer completes
    assign out_advance = !out_valid_reg || m_tready;
    // The held item is resolved against the set as it moves into the result register
    assign commit      = in_valid_reg && out_advance;
    assign s_tready    = !in_valid_reg || out_advance;

    assign probe.commit = commit;
    assign probe.opcode = in_op_reg;

    fekset_store u_store
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .probe     (probe),
        .probe_key (in_key_reg),
        .outcome   (outcome)
    );

    // Capacity register: written straight from the config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    // Input and result valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg  <= opcode_t'(s_tuser);
            in_key_reg <= s_tdata;
        end
        if (commit)
        begin
            out_res_reg <= outcome;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_res_reg.evicted, out_res_reg.hit};

endmodule
